// ===== design/cbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Cassette block framer package
// Shared constants, stream positions and types of the tape block framer.
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam int BLOCK_PAYLOAD = 254;
	localparam int LEADER_COUNT  = 16;
	localparam int L             = LEADER_COUNT;

	localparam int BEG_COUNT = 2 * L + 28;
	localparam int IDX_W     = $clog2(BEG_COUNT);
	localparam int TOTAL_W   = 17;
	localparam int FBL_W     = $clog2((65535 + 12) / BLOCK_PAYLOAD + 1);

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [FBL_W-1:0]   fbl_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [2:0]         reg_index_t;

	localparam logic [31:0]  RECIP      = 32'((64'd1 << 32) / 64'(BLOCK_PAYLOAD));
	localparam total_t       BP_TOTAL   = total_t'(BLOCK_PAYLOAD);
	localparam total_t       HDR_EXTRA  = total_t'(12);
	localparam logic [7:0]   BP_BYTE    = 8'(BLOCK_PAYLOAD);
	localparam logic [7:0]   FULL_LEN   = 8'((BLOCK_PAYLOAD + 2) & 255);
	localparam logic [7:0]   FIRST_FILL = 8'd5;

	// actions
	localparam logic [1:0] ACT_BEGIN  = 2'd0;
	localparam logic [1:0] ACT_DATA   = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// register indexes
	localparam reg_index_t REG_PAYLOAD_LENGTH = 3'd0;
	localparam reg_index_t REG_LOAD_ADDRESS   = 3'd1;
	localparam reg_index_t REG_EXEC_ADDRESS   = 3'd2;
	localparam reg_index_t REG_NAME_EIGHT     = 3'd3;
	localparam reg_index_t REG_NAME_THREE     = 3'd4;

	localparam logic [63:0] NAME_EIGHT_RESET = 64'h2020_2020_2020_2020;
	localparam logic [23:0] NAME_THREE_RESET = 24'h20_2020;

	// tape bytes
	localparam logic [7:0] LEADER_BYTE  = 8'h01;
	localparam logic [7:0] SYNC0_BYTE   = 8'h3C;
	localparam logic [7:0] SYNC1_BYTE   = 8'h5A;
	localparam logic [7:0] HDR_TYPE     = 8'h00;
	localparam logic [7:0] HDR_LEN      = 8'h10;
	localparam logic [7:0] FILE_TYPE    = 8'h02;
	localparam logic [7:0] DATA_TYPE    = 8'h01;
	localparam logic [7:0] END_TYPE     = 8'hFF;
	localparam logic [7:0] END_LEN      = 8'h02;
	localparam logic [7:0] TRAILER_MARK = 8'hFF;
	localparam logic [7:0] ZERO_BYTE    = 8'h00;

	// begin run positions
	localparam idx_t B_SYNC0   = idx_t'(L);
	localparam idx_t B_SYNC1   = idx_t'(L + 1);
	localparam idx_t B_HTYPE   = idx_t'(L + 2);
	localparam idx_t B_HLEN    = idx_t'(L + 3);
	localparam idx_t B_NAME    = idx_t'(L + 4);
	localparam idx_t B_EXT     = idx_t'(L + 12);
	localparam idx_t B_FTYPE   = idx_t'(L + 15);
	localparam idx_t B_PAD0    = idx_t'(L + 16);
	localparam idx_t B_PAD1    = idx_t'(L + 17);
	localparam idx_t B_HCKS    = idx_t'(L + 18);
	localparam idx_t B_DSYNC0  = idx_t'(2 * L + 19);
	localparam idx_t B_DSYNC1  = idx_t'(2 * L + 20);
	localparam idx_t B_DTYPE   = idx_t'(2 * L + 21);
	localparam idx_t B_DLEN    = idx_t'(2 * L + 22);
	localparam idx_t B_DZERO   = idx_t'(2 * L + 23);
	localparam idx_t B_PLEN_HI = idx_t'(2 * L + 24);
	localparam idx_t B_PLEN_LO = idx_t'(2 * L + 25);
	localparam idx_t B_LOAD_HI = idx_t'(2 * L + 26);
	localparam idx_t B_LAST    = idx_t'(2 * L + 27);

	// block break run positions
	localparam idx_t P_SYNC0 = idx_t'(L + 1);
	localparam idx_t P_SYNC1 = idx_t'(L + 2);
	localparam idx_t P_TYPE  = idx_t'(L + 3);
	localparam idx_t P_LEN   = idx_t'(L + 4);

	// finish run positions
	localparam idx_t F_ZERO0   = idx_t'(1);
	localparam idx_t F_ZERO1   = idx_t'(2);
	localparam idx_t F_EXEC_HI = idx_t'(3);
	localparam idx_t F_EXEC_LO = idx_t'(4);
	localparam idx_t F_CKS     = idx_t'(5);
	localparam idx_t F_SYNC0   = idx_t'(L + 6);
	localparam idx_t F_SYNC1   = idx_t'(L + 7);
	localparam idx_t F_TYPE    = idx_t'(L + 8);
	localparam idx_t F_LEN     = idx_t'(L + 9);

	typedef struct packed {
		logic [15:0] payload_length;
		logic [15:0] load_address;
		logic [15:0] exec_address;
		logic [63:0] name_first_eight;
		logic [23:0] name_last_three;
	} cfg_t;

	typedef struct packed {
		logic [7:0] fill;
		logic [7:0] sum;
		fbl_t       fbl;
		logic [7:0] lbl;
	} fstate_t;

	typedef struct packed {
		logic [7:0] tape_byte;
		logic       summed;
		logic       cks;
		logic       brk;
		logic       last;
	} gen_t;

endpackage

// ===== design/cbf_channels.sv =====
// ----------------------------------------------------------------------------
// Cassette block framer channels
// Valid/ready channels for input items, tape bytes and register writes.
// ----------------------------------------------------------------------------
interface cbf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

interface cbf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tape_byte;
	logic       run_end;
	modport source (output valid, tape_byte, run_end, input ready);
	modport sink (input valid, tape_byte, run_end, output ready);
endinterface

interface cbf_cfg_if;
	logic                valid;
	logic                ready;
	cbf_pkg::reg_index_t index;
	logic [63:0]         data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/cassette_block_framer_core.sv =====
// ----------------------------------------------------------------------------
// Cassette block framer core
// The first tape byte of an item goes through the input register and then the
// tape byte register. Throughput: one tape byte per cycle while tape.ready is
// high, from the sequencer's single byte register; an item holds the input until
// its last byte is issued: 1 byte for a payload byte, LEADER_COUNT+6 at a block
// break, 2*LEADER_COUNT+28 for begin and LEADER_COUNT+11 for finish. Reset
// clears valids, counters and framing state and resets the registers.
// ----------------------------------------------------------------------------
module cassette_block_framer_core (
	input  logic      clk,
	input  logic      arst_n,
	cbf_in_if.sink    items,
	cbf_out_if.source tape,
	cbf_cfg_if.sink   cfg
);
	import cbf_pkg::*;

	cfg_t regs;

	cbf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cbf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.tape   (tape),
		.regs   (regs)
	);

endmodule

// ===== design/cbf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Cassette block framer configuration registers
// Holds payload length, addresses and file name written over the cfg channel.
// ----------------------------------------------------------------------------
module cbf_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	cbf_cfg_if.sink       cfg,
	output cbf_pkg::cfg_t regs
);
	import cbf_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.payload_length   <= '0;
			regs.load_address     <= '0;
			regs.exec_address     <= '0;
			regs.name_first_eight <= NAME_EIGHT_RESET;
			regs.name_last_three  <= NAME_THREE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PAYLOAD_LENGTH: regs.payload_length   <= cfg.data[15:0];
				REG_LOAD_ADDRESS:   regs.load_address     <= cfg.data[15:0];
				REG_EXEC_ADDRESS:   regs.exec_address     <= cfg.data[15:0];
				REG_NAME_EIGHT:     regs.name_first_eight <= cfg.data;
				REG_NAME_THREE:     regs.name_last_three  <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/cbf_byte_gen.sv =====
// ----------------------------------------------------------------------------
// Cassette block framer byte generator
// Selects the tape byte at a run position and flags its effect on the sum.
// ----------------------------------------------------------------------------
module cbf_byte_gen (
	input  logic             [1:0] action,
	input  logic             [7:0] data_byte,
	input  cbf_pkg::idx_t          idx,
	input  cbf_pkg::fstate_t       st,
	input  cbf_pkg::cfg_t          regs,
	output cbf_pkg::gen_t          gen
);
	import cbf_pkg::*;

	logic [2:0] k8;
	logic [1:0] k3;
	logic [7:0] name_byte;
	logic [7:0] ext_byte;
	logic [7:0] cks_byte;
	logic [7:0] len_byte;
	logic       brk;

	assign k8       = 3'(idx - B_NAME);
	assign k3       = 2'(idx - B_EXT);
	assign cks_byte = 8'(9'h100 - {1'b0, st.sum});
	assign len_byte = (st.fbl != '0) ? FULL_LEN : st.lbl;
	assign brk      = st.fill >= BP_BYTE;

	assign name_byte = regs.name_first_eight[8 * (7 - int'(k8)) +: 8];

	always_comb begin
		case (k3)
			2'd0:    ext_byte = regs.name_last_three[23:16];
			2'd1:    ext_byte = regs.name_last_three[15:8];
			default: ext_byte = regs.name_last_three[7:0];
		endcase
	end

	always_comb begin
		gen     = '0;
		gen.brk = brk;
		unique case (action)
			ACT_BEGIN: begin
				priority if (idx < B_SYNC0) gen.tape_byte = LEADER_BYTE;
				else if (idx == B_SYNC0) gen.tape_byte = SYNC0_BYTE;
				else if (idx == B_SYNC1) gen.tape_byte = SYNC1_BYTE;
				else if (idx == B_HTYPE) gen.tape_byte = HDR_TYPE;
				else if (idx == B_HLEN) gen.tape_byte = HDR_LEN;
				else if (idx < B_EXT) begin
					gen.tape_byte = name_byte;
					gen.summed    = 1'b1;
				end else if (idx < B_FTYPE) begin
					gen.tape_byte = ext_byte;
					gen.summed    = 1'b1;
				end else if (idx == B_FTYPE) begin
					gen.tape_byte = FILE_TYPE;
					gen.summed    = 1'b1;
				end else if (idx == B_PAD0 || idx == B_PAD1) gen.tape_byte = ZERO_BYTE;
				else if (idx == B_HCKS) begin
					gen.tape_byte = cks_byte;
					gen.cks       = 1'b1;
				end else if (idx < B_DSYNC0) gen.tape_byte = LEADER_BYTE;
				else if (idx == B_DSYNC0) gen.tape_byte = SYNC0_BYTE;
				else if (idx == B_DSYNC1) gen.tape_byte = SYNC1_BYTE;
				else if (idx == B_DTYPE) gen.tape_byte = DATA_TYPE;
				else if (idx == B_DLEN) gen.tape_byte = len_byte;
				else if (idx == B_DZERO) gen.tape_byte = ZERO_BYTE;
				else if (idx == B_PLEN_HI) begin
					gen.tape_byte = regs.payload_length[15:8];
					gen.summed    = 1'b1;
				end else if (idx == B_PLEN_LO) begin
					gen.tape_byte = regs.payload_length[7:0];
					gen.summed    = 1'b1;
				end else if (idx == B_LOAD_HI) begin
					gen.tape_byte = regs.load_address[15:8];
					gen.summed    = 1'b1;
				end else begin
					gen.tape_byte = regs.load_address[7:0];
					gen.summed    = 1'b1;
					gen.last      = 1'b1;
				end
			end
			ACT_DATA: begin
				priority if (!brk) begin
					gen.tape_byte = data_byte;
					gen.summed    = 1'b1;
					gen.last      = 1'b1;
				end else if (idx == '0) begin
					gen.tape_byte = cks_byte;
					gen.cks       = 1'b1;
				end else if (idx < P_SYNC0) gen.tape_byte = LEADER_BYTE;
				else if (idx == P_SYNC0) gen.tape_byte = SYNC0_BYTE;
				else if (idx == P_SYNC1) gen.tape_byte = SYNC1_BYTE;
				else if (idx == P_TYPE) gen.tape_byte = DATA_TYPE;
				else if (idx == P_LEN) gen.tape_byte = len_byte;
				else begin
					gen.tape_byte = data_byte;
					gen.summed    = 1'b1;
					gen.last      = 1'b1;
				end
			end
			ACT_FINISH: begin
				priority if (idx == '0) begin
					gen.tape_byte = TRAILER_MARK;
					gen.summed    = 1'b1;
				end else if (idx == F_ZERO0 || idx == F_ZERO1) begin
					gen.tape_byte = ZERO_BYTE;
					gen.summed    = 1'b1;
				end else if (idx == F_EXEC_HI) begin
					gen.tape_byte = regs.exec_address[15:8];
					gen.summed    = 1'b1;
				end else if (idx == F_EXEC_LO) begin
					gen.tape_byte = regs.exec_address[7:0];
					gen.summed    = 1'b1;
				end else if (idx == F_CKS) begin
					gen.tape_byte = cks_byte;
					gen.cks       = 1'b1;
				end else if (idx < F_SYNC0) gen.tape_byte = LEADER_BYTE;
				else if (idx == F_SYNC0) gen.tape_byte = SYNC0_BYTE;
				else if (idx == F_SYNC1) gen.tape_byte = SYNC1_BYTE;
				else if (idx == F_TYPE) gen.tape_byte = END_TYPE;
				else if (idx == F_LEN) gen.tape_byte = END_LEN;
				else begin
					gen.tape_byte = ZERO_BYTE;
					gen.last      = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/cbf_sequencer.sv =====
// ----------------------------------------------------------------------------
// Cassette block framer sequencer
// Input register, run position counter, framing state and tape byte register.
// ----------------------------------------------------------------------------
module cbf_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	cbf_in_if.sink        items,
	cbf_out_if.source     tape,
	input  cbf_pkg::cfg_t regs
);
	import cbf_pkg::*;

	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] data_s1;
	idx_t       idx_q;
	fstate_t    st_q;

	logic       valid_s2;
	logic [7:0] tape_byte_s2;
	logic       run_end_s2;

	gen_t   gen;
	logic   out_free;
	logic   fire;
	logic   s1_done;
	logic   take;
	total_t total;
	logic [48:0] prod;
	fbl_t   q_est;
	total_t rem;
	logic   rem_ge;

	cbf_byte_gen u_gen (
		.action    (action_s1),
		.data_byte (data_s1),
		.idx       (idx_q),
		.st        (st_q),
		.regs      (regs),
		.gen       (gen)
	);

	assign out_free    = !valid_s2 || tape.ready;
	assign fire        = valid_s1 && out_free && (action_s1 != ACT_NONE);
	assign s1_done     = valid_s1 && ((action_s1 == ACT_NONE) || (out_free && gen.last));
	assign items.ready = !valid_s1 || s1_done;
	assign take        = items.valid && items.ready;

	assign total  = total_t'(regs.payload_length) + HDR_EXTRA;
	assign prod   = 49'(total) * 49'(RECIP);
	assign q_est  = prod[32 +: FBL_W];
	assign rem    = total_t'(total - total_t'(st_q.fbl) * BP_TOTAL);
	assign rem_ge = rem >= BP_TOTAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (take) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1 <= items.action;
			data_s1   <= items.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			if (gen.cks) begin
				st_q.sum <= '0;
			end else if (gen.summed) begin
				st_q.sum <= 8'(st_q.sum + gen.tape_byte);
			end
			unique case (action_s1)
				ACT_BEGIN: begin
					if (idx_q == '0) begin
						st_q.sum <= '0;
						st_q.fbl <= q_est;
					end
					if (idx_q == idx_t'(1)) begin
						st_q.fbl <= st_q.fbl + fbl_t'(rem_ge);
						st_q.lbl <= rem_ge ? 8'(rem - BP_TOTAL) : 8'(rem);
					end
					if (gen.last) begin
						st_q.fill <= FIRST_FILL;
					end
				end
				ACT_DATA: begin
					if (gen.brk && idx_q == '0 && st_q.fbl != '0) begin
						st_q.fbl <= st_q.fbl - fbl_t'(1);
					end
					if (gen.last) begin
						st_q.fill <= gen.brk ? 8'd1 : 8'(st_q.fill + 8'd1);
					end
				end
				ACT_FINISH: begin
					if (gen.last) begin
						st_q.fill <= '0;
						st_q.sum  <= '0;
						st_q.fbl  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (tape.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			tape_byte_s2 <= gen.tape_byte;
			run_end_s2   <= gen.last;
		end
	end

	assign tape.valid     = valid_s2;
	assign tape.tape_byte = tape_byte_s2;
	assign tape.run_end   = run_end_s2;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fill <= BP_BYTE)
		else $error("block fill beyond block payload");

	a_cks_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && gen.cks |=> st_q.sum == '0)
		else $error("sum not cleared after checksum");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_q <= B_LAST)
		else $error("run position beyond longest run");

	a_lbl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire && action_s1 == ACT_BEGIN && idx_q == idx_t'(1) |=> st_q.lbl < BP_BYTE)
		else $error("last block length not reduced");
`endif

endmodule
